FILE: design/slt_pkg.sv
// Shared types, widths and constants for the sound level time weighting block.
// No dependencies; compiled first.
package slt_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 24;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 24;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_MODE  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA_FAST = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA_SLOW = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DB_OFFSET  = 8'd3;

    // Time weighting modes
    localparam int TIME_MODE_WIDTH = 2;
    localparam logic [TIME_MODE_WIDTH-1:0] TM_DIRECT = 2'd0;
    localparam logic [TIME_MODE_WIDTH-1:0] TM_FAST   = 2'd1;
    localparam logic [TIME_MODE_WIDTH-1:0] TM_SLOW   = 2'd2;

    // Smoothing factor, one extra bit so that exactly one can be held
    localparam int ALPHA_WIDTH     = 24;
    localparam int ALPHA_SEL_WIDTH = ALPHA_WIDTH + 1;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_FAST_RESET = 24'd2796;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_SLOW_RESET = 24'd350;

    // Mean square accumulator
    localparam int MS_WIDTH = 54;

    // Shared shift-add multiplier
    localparam int MUL_A_WIDTH   = MS_WIDTH;
    localparam int MUL_B_WIDTH   = 31;
    localparam int MUL_ACC_WIDTH = MUL_A_WIDTH + 2;
    localparam int MUL_P_WIDTH   = MUL_ACC_WIDTH + MUL_B_WIDTH;
    localparam int MUL_CNT_WIDTH = $clog2(MUL_B_WIDTH + 1);

    // log2 stage: mantissa with its leading one at bit MANT_WIDTH-1
    localparam int MANT_WIDTH       = 31;
    localparam int NORM_SHIFT_WIDTH = $clog2(MS_WIDTH);
    localparam int LOG_FRAC_BITS    = 16;
    localparam int EXP_WIDTH        = 8;
    localparam int LOG_WIDTH        = EXP_WIDTH + LOG_FRAC_BITS;
    localparam int LOG_ITER_WIDTH   = $clog2(LOG_FRAC_BITS);
    localparam logic [LOG_ITER_WIDTH-1:0] LOG_ITER_LAST = LOG_ITER_WIDTH'(LOG_FRAC_BITS - 1);

    // 10*log10(2) in unsigned Q2.24, applied as (|L| * K + 2^31) >> 32
    localparam logic [25:0] TEN_LOG10_2_Q24 = 26'd50504453;
    localparam int SCALE_SHIFT = 32;
    localparam logic [MUL_ACC_WIDTH-1:0] SCALE_ROUND = MUL_ACC_WIDTH'(1) << (SCALE_SHIFT - 1);

    // Level output, signed Q8.8
    localparam int LEVEL_WIDTH   = 16;
    localparam int DB_MAG_WIDTH  = 17;
    localparam int DB_VAL_WIDTH  = DB_MAG_WIDTH + 1;
    localparam int DB_SUM_WIDTH  = DB_VAL_WIDTH + 1;
    localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MAX = 16'sh7FFF;
    localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MIN = 16'sh8000;

    // Multiplier request and response
    typedef struct packed {
        logic                     start;
        logic [MUL_A_WIDTH-1:0]   mcand;
        logic [MUL_B_WIDTH-1:0]   mplier;
        logic [MUL_ACC_WIDTH-1:0] addend;
    } mul_req_t;

    typedef struct packed {
        logic                   done;
        logic [MUL_P_WIDTH-1:0] product;
    } mul_rsp_t;

    // Normalizer request and response
    typedef struct packed {
        logic                start;
        logic [MS_WIDTH-1:0] value;
    } norm_req_t;

    typedef struct packed {
        logic                        done;
        logic [NORM_SHIFT_WIDTH-1:0] shift;
        logic [MANT_WIDTH-1:0]       mant;
    } norm_rsp_t;

endpackage

FILE: design/slt_if.sv
// Valid/ready channel interfaces: sample input, level output, register writes.
// Depends on slt_pkg.
interface slt_sample_if #(
    parameter int SAMPLE_WIDTH = slt_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface slt_level_if;
    import slt_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [LEVEL_WIDTH-1:0] level_db;
    logic                          at_floor;

    modport source (output valid, output level_db, output at_floor, input ready);
    modport sink   (input valid, input level_db, input at_floor, output ready);
endinterface

interface slt_cfg_if;
    import slt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/slt_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, product = mcand * mplier + addend.
// Depends on slt_pkg.
module slt_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  slt_pkg::mul_req_t req,
    output slt_pkg::mul_rsp_t rsp
);
    import slt_pkg::*;

    logic [MUL_A_WIDTH-1:0]   mcand_reg;
    logic [MUL_ACC_WIDTH-1:0] acc_reg;
    logic [MUL_B_WIDTH-1:0]   shr_reg;
    logic [MUL_CNT_WIDTH-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [MUL_ACC_WIDTH-1:0] sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = acc_reg + (shr_reg[0] ? MUL_ACC_WIDTH'(mcand_reg) : '0);

    // Accumulate and shift right; low product bits fill in behind the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcand_reg <= '0;
            acc_reg   <= '0;
            shr_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                mcand_reg <= req.mcand;
                acc_reg   <= req.addend;
                shr_reg   <= req.mplier;
                cnt_reg   <= MUL_CNT_WIDTH'(MUL_B_WIDTH);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= sum >> 1;
                shr_reg <= {sum[0], shr_reg[MUL_B_WIDTH-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {acc_reg, shr_reg};

endmodule

FILE: design/slt_norm.sv
// Leading-one normalizer: shifts the mean square left one bit per cycle
// until its top bit is set. Depends on slt_pkg.
module slt_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  slt_pkg::norm_req_t req,
    output slt_pkg::norm_rsp_t rsp
);
    import slt_pkg::*;

    logic [MS_WIDTH-1:0]         val_reg;
    logic [NORM_SHIFT_WIDTH-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // Shift until normalized; the count limit only guards a zero input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                val_reg  <= req.value;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (val_reg[MS_WIDTH-1] || cnt_reg == NORM_SHIFT_WIDTH'(MS_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    val_reg <= val_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Top bits form the mantissa; bits below it are truncated
    assign rsp.done  = done_reg;
    assign rsp.shift = cnt_reg;
    assign rsp.mant  = val_reg[MS_WIDTH-1 -: MANT_WIDTH];

endmodule

FILE: design/sound_level_time_weighting.sv
// Sound level meter with exponential time weighting, one level per sample.
// One item at a time. The shared shift-add multiplier runs 19 times per item, 16 of them
// for the log2 fraction bits, and only twice when the mean square is zero.
// Async active-low reset: mean square zero, registers at their defaults, no result pending.
module sound_level_time_weighting #(
    parameter int SAMPLE_WIDTH    = slt_pkg::SAMPLE_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = slt_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    slt_sample_if.sink   samples,
    slt_level_if.source  levels,
    slt_cfg_if.sink      cfg
);
    import slt_pkg::*;

    localparam int MS_FRAC   = MS_WIDTH - 2 * SAMPLE_WIDTH;
    localparam int LOG2_BIAS = 2 * SAMPLE_WIDTH - 1;
    localparam logic [ALPHA_SEL_WIDTH-1:0] ALPHA_ONE =
        ALPHA_SEL_WIDTH'(1) << ALPHA_FRAC_BITS;
    localparam logic [MUL_ACC_WIDTH-1:0] ROUND_HALF =
        MUL_ACC_WIDTH'(1) << (ALPHA_FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_DIFF,
        S_SMOOTH,
        S_CHECK,
        S_NORM,
        S_LOG,
        S_ABS,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    logic [TIME_MODE_WIDTH-1:0]    time_mode_reg;
    logic [ALPHA_WIDTH-1:0]        alpha_fast_reg;
    logic [ALPHA_WIDTH-1:0]        alpha_slow_reg;
    logic signed [LEVEL_WIDTH-1:0] db_offset_reg;
    logic [MS_WIDTH-1:0]           ms_reg;
    logic [MS_WIDTH-1:0]           sq_reg;
    logic                          up_reg;
    logic                          floor_reg;
    logic [EXP_WIDTH-1:0]          exp_reg;
    logic [LOG_FRAC_BITS-1:0]      frac_reg;
    logic [LOG_ITER_WIDTH-1:0]     iter_reg;
    logic                          log_neg_reg;
    logic                          out_valid_reg;
    logic signed [LEVEL_WIDTH-1:0] out_level_reg;
    logic                          out_floor_reg;
    mul_req_t                      mul_req_reg;
    norm_req_t                     norm_req_reg;

    mul_rsp_t                      mul_rsp;
    norm_rsp_t                     norm_rsp;

    logic [SAMPLE_WIDTH-1:0]       raw;
    logic [SAMPLE_WIDTH-1:0]       mag;
    logic [ALPHA_SEL_WIDTH-1:0]    alpha_pick;
    logic [ALPHA_SEL_WIDTH-1:0]    alpha_sel;
    logic                          ms_up;
    logic [MS_WIDTH-1:0]           diff;
    logic [MS_WIDTH-1:0]           step;
    logic [MS_WIDTH-1:0]           ms_new;
    logic [MANT_WIDTH:0]           sq_wide;
    logic [MANT_WIDTH-1:0]         mant_new;
    logic [LOG_WIDTH-1:0]          log_val;
    logic [LOG_WIDTH-1:0]          log_mag;
    logic [DB_MAG_WIDTH-1:0]       db_mag;
    logic signed [DB_VAL_WIDTH-1:0] db_val;
    logic signed [DB_SUM_WIDTH-1:0] db_sum;
    logic signed [LEVEL_WIDTH-1:0] db_sat;
    logic                          out_free;

    // Shared multiplier and normalizer
    slt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req_reg),
        .rsp   (mul_rsp)
    );

    slt_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req_reg),
        .rsp   (norm_rsp)
    );

    // Sample magnitude; the most negative sample maps to 2^(SAMPLE_WIDTH-1)
    assign raw = samples.sample;
    assign mag = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;

    // Smoothing factor by mode, clamped to one
    always_comb
    begin
        unique case (time_mode_reg)
            TM_DIRECT: alpha_pick = ALPHA_ONE;
            TM_FAST:   alpha_pick = ALPHA_SEL_WIDTH'(alpha_fast_reg);
            TM_SLOW:   alpha_pick = ALPHA_SEL_WIDTH'(alpha_slow_reg);
            default:   alpha_pick = ALPHA_ONE;
        endcase
        alpha_sel = (alpha_pick > ALPHA_ONE) ? ALPHA_ONE : alpha_pick;
    end

    // Distance from mean square to the new square, and the rounded step
    assign ms_up  = sq_reg >= ms_reg;
    assign diff   = ms_up ? (sq_reg - ms_reg) : (ms_reg - sq_reg);
    assign step   = mul_rsp.product[ALPHA_FRAC_BITS +: MS_WIDTH];
    assign ms_new = up_reg ? (ms_reg + step) : (ms_reg - step);

    // One log2 fraction bit per squaring of the mantissa
    assign sq_wide  = mul_rsp.product[MANT_WIDTH-1 +: MANT_WIDTH+1];
    assign mant_new = sq_wide[MANT_WIDTH] ? sq_wide[MANT_WIDTH:1] : sq_wide[MANT_WIDTH-1:0];

    // Signed log2 in Q.16 and its magnitude
    assign log_val = {exp_reg, frac_reg};
    assign log_mag = log_val[LOG_WIDTH-1] ? (~log_val + 1'b1) : log_val;

    // dB level: restore sign, add offset, saturate
    always_comb
    begin
        db_mag = mul_rsp.product[SCALE_SHIFT +: DB_MAG_WIDTH];
        db_val = DB_VAL_WIDTH'(db_mag);
        if (log_neg_reg)
        begin
            db_val = -db_val;
        end
        db_sum = DB_SUM_WIDTH'(db_val) + DB_SUM_WIDTH'(db_offset_reg);
        if (db_sum > DB_SUM_WIDTH'(LEVEL_MAX))
        begin
            db_sat = LEVEL_MAX;
        end
        else if (db_sum < DB_SUM_WIDTH'(LEVEL_MIN))
        begin
            db_sat = LEVEL_MIN;
        end
        else
        begin
            db_sat = db_sum[LEVEL_WIDTH-1:0];
        end
    end

    assign out_free = !out_valid_reg || levels.ready;

    // Sequencer, configuration registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            time_mode_reg  <= TM_SLOW;
            alpha_fast_reg <= ALPHA_FAST_RESET;
            alpha_slow_reg <= ALPHA_SLOW_RESET;
            db_offset_reg  <= '0;
            ms_reg         <= '0;
            sq_reg         <= '0;
            up_reg         <= 1'b0;
            floor_reg      <= 1'b0;
            exp_reg        <= '0;
            frac_reg       <= '0;
            iter_reg       <= '0;
            log_neg_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_level_reg  <= '0;
            out_floor_reg  <= 1'b0;
            mul_req_reg    <= '0;
            norm_req_reg   <= '0;
        end
        else
        begin
            mul_req_reg.start  <= 1'b0;
            norm_req_reg.start <= 1'b0;

            // Output transfer frees the slot
            if (out_valid_reg && levels.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Register writes; unknown indexes are dropped
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TIME_MODE:  time_mode_reg  <= cfg.data[TIME_MODE_WIDTH-1:0];
                    REG_ALPHA_FAST: alpha_fast_reg <= cfg.data[ALPHA_WIDTH-1:0];
                    REG_ALPHA_SLOW: alpha_slow_reg <= cfg.data[ALPHA_WIDTH-1:0];
                    REG_DB_OFFSET:  db_offset_reg  <= cfg.data[LEVEL_WIDTH-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (samples.valid)
                    begin
                        mul_req_reg <= '{start: 1'b1, mcand: MUL_A_WIDTH'(mag),
                                         mplier: MUL_B_WIDTH'(mag), addend: '0};
                        state_reg   <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    if (mul_rsp.done)
                    begin
                        sq_reg    <= mul_rsp.product[MS_WIDTH-1:0] << MS_FRAC;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    up_reg      <= ms_up;
                    mul_req_reg <= '{start: 1'b1, mcand: diff,
                                     mplier: MUL_B_WIDTH'(alpha_sel), addend: ROUND_HALF};
                    state_reg   <= S_SMOOTH;
                end
                S_SMOOTH:
                begin
                    if (mul_rsp.done)
                    begin
                        ms_reg    <= ms_new;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (ms_reg == '0)
                    begin
                        floor_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        floor_reg    <= 1'b0;
                        norm_req_reg <= '{start: 1'b1, value: ms_reg};
                        state_reg    <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (norm_rsp.done)
                    begin
                        exp_reg     <= EXP_WIDTH'(LOG2_BIAS) - EXP_WIDTH'(norm_rsp.shift);
                        frac_reg    <= '0;
                        iter_reg    <= '0;
                        mul_req_reg <= '{start: 1'b1, mcand: MUL_A_WIDTH'(norm_rsp.mant),
                                         mplier: MUL_B_WIDTH'(norm_rsp.mant), addend: '0};
                        state_reg   <= S_LOG;
                    end
                end
                S_LOG:
                begin
                    if (mul_rsp.done)
                    begin
                        frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq_wide[MANT_WIDTH]};
                        if (iter_reg == LOG_ITER_LAST)
                        begin
                            state_reg <= S_ABS;
                        end
                        else
                        begin
                            iter_reg    <= iter_reg + 1'b1;
                            mul_req_reg <= '{start: 1'b1, mcand: MUL_A_WIDTH'(mant_new),
                                             mplier: MUL_B_WIDTH'(mant_new), addend: '0};
                        end
                    end
                end
                S_ABS:
                begin
                    log_neg_reg <= log_val[LOG_WIDTH-1];
                    mul_req_reg <= '{start: 1'b1, mcand: MUL_A_WIDTH'(TEN_LOG10_2_Q24),
                                     mplier: MUL_B_WIDTH'(log_mag), addend: SCALE_ROUND};
                    state_reg   <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (mul_rsp.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Multiplier product stays put while waiting for the slot
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= floor_reg ? LEVEL_MIN : db_sat;
                        out_floor_reg <= floor_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs
    assign samples.ready   = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign levels.valid    = out_valid_reg;
    assign levels.level_db = out_level_reg;
    assign levels.at_floor = out_floor_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("input taken again right after a transfer");

    a_floor_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_floor_reg |-> out_level_reg == LEVEL_MIN)
        else $error("floor result without minimum level");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_SQUARE || state_reg == S_SMOOTH ||
                          state_reg == S_LOG || state_reg == S_SCALE))
        else $error("multiplier finished outside a wait state");

    a_ms_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_SMOOTH |=> $stable(ms_reg))
        else $error("mean square changed outside the smoothing step");

endmodule

FILE: tb/tb.sv
// Self-checking bench for sound_level_time_weighting: drives samples and register writes,
// predicts every level in a local bit-exact model and checks the transfers in order.
// Depends on slt_pkg, the slt_*_if interfaces and the design top.
module tb;
    import slt_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int AFB          = ALPHA_FRAC_BITS_DEF;
    localparam int MS_FRAC_BITS = MS_WIDTH - 2 * SW;
    localparam logic [63:0] TEN_LOG2_Q24 = 64'd50504453;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = 8'hFF;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_TAIL   = 800;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 107;
    localparam int SHOW_LIMIT   = 10;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        logic signed [LEVEL_WIDTH-1:0] level_db;
        logic                          at_floor;
    } level_t;

    typedef enum int {BURST_FULL, BURST_SMALL, BURST_SILENT, BURST_EDGE, BURST_MID} burst_t;

    logic clk;
    logic rst_n;

    slt_sample_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
    slt_level_if                       level_ch ();
    slt_cfg_if                         cfg_ch ();

    sound_level_time_weighting #(
        .SAMPLE_WIDTH    (SW),
        .ALPHA_FRAC_BITS (AFB)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .levels  (level_ch),
        .cfg     (cfg_ch)
    );

    // Local copy of the registers and the smoother state
    logic [TIME_MODE_WIDTH-1:0]    tm_q          = TM_SLOW;
    logic [ALPHA_WIDTH-1:0]        alpha_fast_q  = ALPHA_FAST_RESET;
    logic [ALPHA_WIDTH-1:0]        alpha_slow_q  = ALPHA_SLOW_RESET;
    logic signed [LEVEL_WIDTH-1:0] offset_q      = '0;
    logic [MS_WIDTH-1:0]           ms_q          = '0;

    sample_t feed_q[$];
    level_t  levels_due[$];
    int      mismatches    = 0;
    int      results_seen  = 0;
    int      idle_pct      = 37;
    bit      sample_taken  = 1'b0;
    burst_t  burst_kind    = BURST_FULL;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Fold one sample into the mean square and form the level it produces
    function automatic level_t next_level(input sample_t smp);
        logic signed [SW:0]   ext;
        logic [SW:0]          mag;
        logic [24:0]          alpha;
        logic [24:0]          unity;
        logic [63:0]          sq, ms64, d, stp, m, frac, lmag, scaled;
        logic [79:0]          prod;
        int                   lead;
        longint               l2, lvl;
        level_t               res;

        ext   = smp;
        mag   = ext[SW] ? -ext : ext;
        sq    = (64'(mag) * 64'(mag)) << MS_FRAC_BITS;
        unity = 25'(1) << AFB;
        case (tm_q)
            TM_FAST: alpha = {1'b0, alpha_fast_q};
            TM_SLOW: alpha = {1'b0, alpha_slow_q};
            default: alpha = unity;
        endcase
        if (alpha > unity)
            alpha = unity;

        // Move toward the new square, rounded half up, never overshooting
        ms64 = 64'(ms_q);
        d    = (sq >= ms64) ? sq - ms64 : ms64 - sq;
        prod = 80'(d) * 80'(alpha) + (80'(1) << (AFB - 1));
        stp  = 64'(prod >> AFB);
        if (stp > d)
            stp = d;
        ms64 = (sq >= ms64) ? ms64 + stp : ms64 - stp;
        ms_q = ms64[MS_WIDTH-1:0];

        if (ms_q == '0)
        begin
            res.level_db = LEVEL_MIN;
            res.at_floor = 1'b1;
            return res;
        end

        // log2 in Q.16: leading one position, then fraction bits by squaring
        lead = 0;
        for (int i = 0; i < MS_WIDTH; i++)
            if (ms_q[i])
                lead = i;
        m = (lead > 30) ? 64'(ms_q) >> (lead - 30) : 64'(ms_q) << (30 - lead);
        frac = '0;
        repeat (16)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        l2 = longint'(lead - MS_FRAC_BITS) * 65536 + longint'(frac);

        // Scale to dB, magnitude rounded half away from zero, then offset and clip
        lmag   = (l2 < 0) ? 64'(-l2) : 64'(l2);
        scaled = (lmag * TEN_LOG2_Q24 + (64'd1 << 31)) >> 32;
        lvl    = (l2 < 0) ? -longint'(scaled) : longint'(scaled);
        lvl    = lvl + longint'(offset_q);
        if (lvl > 32767)
            lvl = 32767;
        if (lvl < -32768)
            lvl = -32768;
        res.level_db = 16'(lvl);
        res.at_floor = 1'b0;
        return res;
    endfunction

    // Random sample, drawn in bursts of one kind so decays and rises run deep
    function automatic sample_t next_sample();
        int v;

        if ($urandom_range(15) == 0)
            burst_kind = burst_t'($urandom_range(4));
        case (burst_kind)
            BURST_FULL:   return SW'($urandom);
            BURST_SMALL:  return SW'($signed($urandom_range(510)) - 255);
            BURST_SILENT: return '0;
            BURST_EDGE:
            begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return -16'sd1;
                    3:       return 16'sd1;
                    default: return '0;
                endcase
            end
            default:
            begin
                v = $urandom_range(4095);
                return $urandom_range(1) ? SW'(-v) : SW'(v);
            end
        endcase
    endfunction

    function automatic logic [ALPHA_WIDTH-1:0] random_alpha();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return ALPHA_WIDTH'($urandom);
            3:       return ALPHA_WIDTH'($urandom_range(65535));
            default: return ALPHA_WIDTH'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic signed [LEVEL_WIDTH-1:0] random_offset();
        case ($urandom_range(4))
            0:       return LEVEL_MAX;
            1:       return LEVEL_MIN;
            default: return LEVEL_WIDTH'($urandom);
        endcase
    endfunction

    // One register write; valid stays high until released
    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender holds off until every queued sample has produced its level
    task automatic wait_idle();
        @(posedge clk);
        while (feed_q.size() != 0 || sample_ch.valid || levels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [TIME_MODE_WIDTH-1:0] tm,
                              input logic [ALPHA_WIDTH-1:0] af,
                              input logic [ALPHA_WIDTH-1:0] asl,
                              input logic signed [LEVEL_WIDTH-1:0] off);
        wait_idle();
        cfg_write(REG_TIME_MODE, {22'($urandom), tm});
        cfg_write(REG_ALPHA_FAST, af);
        cfg_write(REG_ALPHA_SLOW, asl);
        cfg_write(REG_DB_OFFSET, {8'($urandom), off});
        cfg_release();
    endtask

    task automatic report(input bit has_want, input level_t want, input level_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
        begin
            if (has_want)
                $display("result %0d: expected level %0d floor %0b, got level %0d floor %0b",
                         results_seen, want.level_db, want.at_floor,
                         got.level_db, got.at_floor);
            else
                $display("result %0d: unexpected level %0d floor %0b",
                         results_seen, got.level_db, got.at_floor);
        end
    endtask

    // Sample driver: next item at the falling edge once the last one transferred
    always @(negedge clk)
    begin
        if (!sample_ch.valid || sample_taken)
        begin
            if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= feed_q.pop_front();
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Level receiver back-pressure
    always @(negedge clk)
        level_ch.ready <= ($urandom_range(99) >= idle_pct);

    // Monitor: register shadow, prediction on sample transfer, check on level transfer
    always @(posedge clk)
    begin : monitor
        level_t got;
        level_t want;

        sample_taken = sample_ch.valid && sample_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_TIME_MODE:  tm_q         = cfg_ch.data[TIME_MODE_WIDTH-1:0];
                    REG_ALPHA_FAST: alpha_fast_q = cfg_ch.data[ALPHA_WIDTH-1:0];
                    REG_ALPHA_SLOW: alpha_slow_q = cfg_ch.data[ALPHA_WIDTH-1:0];
                    REG_DB_OFFSET:  offset_q     = cfg_ch.data[LEVEL_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (sample_taken)
                levels_due.push_back(next_level(sample_ch.sample));
            if (level_ch.valid && level_ch.ready)
            begin
                got.level_db = level_ch.level_db;
                got.at_floor = level_ch.at_floor;
                want = '0;
                if (levels_due.size() == 0)
                    report(1'b0, want, got);
                else
                begin
                    want = levels_due.pop_front();
                    if (got.level_db !== want.level_db || got.at_floor !== want.at_floor)
                        report(1'b1, want, got);
                end
                results_seen++;
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (level_ch.valid && level_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus: reset, directed corners, then randomized phases
    initial
    begin
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        level_ch.ready   = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: slow weighting, silence first so the floor shows
        feed_q.push_back(16'sd0);
        feed_q.push_back(16'sh7FFF);

        // Direct mode across the sample extremes and alternating bit patterns
        set_config(TM_DIRECT, ALPHA_FAST_RESET, ALPHA_SLOW_RESET, 16'sd0);
        feed_q.push_back(16'sh8000);
        feed_q.push_back(16'sh7FFF);
        feed_q.push_back(16'sd1);
        feed_q.push_back(-16'sd1);
        feed_q.push_back(16'sd0);
        feed_q.push_back(16'sh5555);
        feed_q.push_back(16'shAAAA);

        // Top offset: clips high; silence stays at the floor without offset
        set_config(TM_DIRECT, ALPHA_FAST_RESET, ALPHA_SLOW_RESET, LEVEL_MAX);
        feed_q.push_back(16'sh8000);
        feed_q.push_back(16'sd0);

        // Half-step fast decay into sub-LSB mean square with bottom offset: clips low
        set_config(TM_FAST, 24'h800000, ALPHA_SLOW_RESET, LEVEL_MIN);
        feed_q.push_back(16'sd1);
        feed_q.push_back(16'sd0);
        feed_q.push_back(16'sd0);

        // Undefined mode behaves as direct
        set_config(2'd3, 24'h800000, ALPHA_SLOW_RESET, 16'sd0);
        feed_q.push_back(16'sd0);
        feed_q.push_back(16'sd1000);

        // Zero factor holds the mean square
        set_config(TM_SLOW, 24'h800000, 24'd0, -16'sd1234);
        feed_q.push_back(16'sh7FFF);
        feed_q.push_back(16'sh8000);

        // Largest factor just below one
        set_config(TM_FAST, 24'hFFFFFF, 24'd0, 16'sd2560);
        feed_q.push_back(16'sh8000);
        feed_q.push_back(16'sd5);

        // Writes to unmapped indexes change nothing
        wait_idle();
        cfg_write(REG_UNUSED_LO, 24'($urandom));
        cfg_write(REG_UNUSED_HI, 24'hFFFFFF);
        cfg_release();
        feed_q.push_back(16'sd77);

        // Random phases, one of them without any idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            idle_pct = (ph == 3) ? 0 : 37;
            set_config(TIME_MODE_WIDTH'($urandom_range(3)), random_alpha(), random_alpha(),
                       random_offset());
            repeat (PHASE_ITEMS)
                feed_q.push_back(next_sample());
        end

        wait_idle();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && levels_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
